// File: design/api_frame_transmit_encoder_top_defines.svh
// Assertion macros for the frame transmit encoder.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef API_FRAME_TRANSMIT_ENCODER_TOP_DEFINES_SVH
`define API_FRAME_TRANSMIT_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define AFE_ASSERT_IMM(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("afe assertion failed");
// pre holds -> post holds in the next cycle
`define AFE_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("afe assertion failed");
`else
`define AFE_ASSERT_IMM(label, pre, post)
`define AFE_ASSERT_NXT(label, pre, post)
`endif

`endif

// File: design/afe_pkg.sv
package afe_pkg;

	localparam logic [7:0] ESC_MARK  = 8'h7D;
	localparam logic [7:0] START_DLM = 8'h7E;
	localparam logic [7:0] XON_CHAR  = 8'h11;
	localparam logic [7:0] XOFF_CHAR = 8'h13;
	localparam logic [7:0] ESC_FLIP  = 8'h20;
	localparam logic [7:0] CK_BASE   = 8'hFF;

	localparam logic [1:0] POS_DELIM   = 2'd0;
	localparam logic [1:0] POS_LEN_HI  = 2'd1;
	localparam logic [1:0] POS_LEN_LO  = 2'd2;
	localparam logic [1:0] POS_PAYLOAD = 2'd3;

	localparam int MAX_WORDS = 4;

	// Wire words produced by one input word
	typedef struct packed {
		logic [MAX_WORDS-1:0][7:0] bytes;
		logic [2:0]                count;
		logic                      has_end;
	} bundle_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == ESC_MARK) || (b == START_DLM) || (b == XON_CHAR) || (b == XOFF_CHAR);
	endfunction

endpackage

// File: design/api_frame_transmit_encoder_top.sv
// Escaped frame transmit encoder.
// An accepted input word's first wire word appears in the cycle after it.
// One wire word per cycle while out_stall is low; an input word expands to
// one to four wire words, and the next is taken as the last of them leaves.
// Reset: arst_n clears header position, checksum sum and the output valid.
module api_frame_transmit_encoder_top
	import afe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       frame_end
);

	bundle_t bundle;
	logic    accept;

	// Accept a word when the serializer can take its bundle
	assign accept = in_valid && !in_stall;

	afe_encode u_encode (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.accept    (accept),
		.bundle    (bundle)
	);

	afe_serialize u_serialize (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.bundle_in (bundle),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

endmodule

// File: design/afe_encode.sv
module afe_encode
	import afe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       accept,
	output bundle_t    bundle
);

	logic [1:0] header_position_q;
	logic [7:0] payload_sum_q;

	logic       in_payload;
	logic       close_frame;
	logic [7:0] sum_next;
	logic [7:0] ck;
	logic       esc_data;
	logic       esc_ck;
	logic [7:0] c0;
	logic [7:0] c1;
	logic [2:0] n_data;
	logic [2:0] n_ck;

	// Build the escaped word list for this input word
	always_comb begin
		in_payload  = (header_position_q == POS_PAYLOAD);
		close_frame = in_payload && last_byte;
		sum_next    = payload_sum_q + data_byte;
		ck          = CK_BASE - sum_next;
		esc_data    = needs_escape(data_byte) && (header_position_q != POS_DELIM);
		esc_ck      = needs_escape(ck);
		c0          = esc_ck ? ESC_MARK : ck;
		c1          = ck ^ ESC_FLIP;
		n_data      = esc_data ? 3'd2 : 3'd1;
		n_ck        = esc_ck ? 3'd2 : 3'd1;

		bundle.bytes[0] = esc_data ? ESC_MARK : data_byte;
		bundle.bytes[1] = esc_data ? (data_byte ^ ESC_FLIP) : c0;
		bundle.bytes[2] = esc_data ? c0 : c1;
		bundle.bytes[3] = c1;
		bundle.count    = close_frame ? (n_data + n_ck) : n_data;
		bundle.has_end  = close_frame;
	end

	// Advance header position and running sum per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_position_q <= POS_DELIM;
			payload_sum_q     <= 8'd0;
		end else if (accept) begin
			if (close_frame) begin
				header_position_q <= POS_DELIM;
				payload_sum_q     <= 8'd0;
			end else if (in_payload) begin
				payload_sum_q <= sum_next;
			end else begin
				header_position_q <= header_position_q + 2'd1;
			end
		end
	end

endmodule

// File: design/afe_serialize.sv
`include "api_frame_transmit_encoder_top_defines.svh"

module afe_serialize
	import afe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  bundle_t    bundle_in,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       frame_end
);

	logic       valid_q;
	bundle_t    bundle_q;
	logic [1:0] idx_q;

	logic last_word;
	logic done;
	logic load_ok;
	logic load;

	// Drive the current wire word from the held bundle
	always_comb begin
		last_word = ({1'b0, idx_q} == (bundle_q.count - 3'd1));
		done      = valid_q && !out_stall && last_word;
		load_ok   = !valid_q || done;
		load      = in_valid && load_ok;
		in_stall  = !load_ok;
		out_valid = valid_q;
		out_byte  = bundle_q.bytes[idx_q];
		frame_end = bundle_q.has_end && last_word;
	end

	// Hold the bundle control and step through its words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (valid_q && !out_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Capture payload on load only
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle_in;
		end
	end

	`AFE_ASSERT_IMM(a_count_range, valid_q, (bundle_q.count != 3'd0) && (bundle_q.count <= 3'd4))
	`AFE_ASSERT_IMM(a_idx_in_bundle, valid_q, {1'b0, idx_q} < bundle_q.count)
	`AFE_ASSERT_NXT(a_load_takes, load, valid_q && (idx_q == 2'd0))
	`AFE_ASSERT_NXT(a_stall_holds, valid_q && out_stall, valid_q && $stable(idx_q))

endmodule

// File: bench/tb_top.sv
module tb_top;
	import afe_pkg::*;

	// One unescaped frame word as it goes in
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	// One escaped word as it should come out on the wire
	typedef struct packed {
		logic [7:0] octet;
		logic       is_end;
	} wire_word_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       frame_end;

	frame_word_t frame_words[$];
	wire_word_t  wire_queue[$];
	wire_word_t  want;

	// Encoder state as the bench tracks it
	logic [1:0] hdr_pos = POS_DELIM;
	logic [7:0] run_sum = 8'h00;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int err_count     = 0;

	api_frame_transmit_encoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic is_special(input logic [7:0] b);
		case (b)
			ESC_MARK, START_DLM, XON_CHAR, XOFF_CHAR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Queue one wire byte, split into mark and flipped byte when it is special
	task automatic push_wire(input logic [7:0] b, input logic fe);
		if (is_special(b)) begin
			wire_queue.push_back('{octet: ESC_MARK, is_end: 1'b0});
			wire_queue.push_back('{octet: b ^ ESC_FLIP, is_end: fe});
		end else begin
			wire_queue.push_back('{octet: b, is_end: fe});
		end
	endtask

	// Work out the wire words that one accepted input word causes
	task automatic encode_word(input logic [7:0] b, input logic last);
		if (hdr_pos == POS_DELIM) begin
			wire_queue.push_back('{octet: b, is_end: 1'b0});
			hdr_pos = POS_LEN_HI;
		end else if (hdr_pos != POS_PAYLOAD) begin
			push_wire(b, 1'b0);
			hdr_pos = hdr_pos + 2'd1;
		end else begin
			push_wire(b, 1'b0);
			run_sum = run_sum + b;
			if (last) begin
				push_wire(CK_BASE - run_sum, 1'b1);
				hdr_pos = POS_DELIM;
				run_sum = 8'h00;
			end
		end
	endtask

	// Random byte, biased toward the values that need escaping
	function automatic logic [7:0] pick_octet(input int pct_special);
		if ($urandom_range(99) < pct_special) begin
			case ($urandom_range(3))
				0: return ESC_MARK;
				1: return START_DLM;
				2: return XON_CHAR;
				default: return XOFF_CHAR;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic add_word(input logic [7:0] b, input logic last);
		frame_words.push_back('{data: b, last: last});
	endtask

	// Queue whole frames with random content until about n_items words are pending
	task automatic queue_frames(input int n_items);
		int count;
		int plen;
		count = 0;
		while (count < n_items) begin
			// delimiter, mostly the real one, and two length bytes with stray flags
			add_word(($urandom_range(9) == 0) ? pick_octet(20) : START_DLM,
				$urandom_range(4) == 0);
			add_word(pick_octet(25), $urandom_range(4) == 0);
			add_word(pick_octet(25), $urandom_range(4) == 0);
			plen = ($urandom_range(19) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
			for (int i = 0; i < plen; i++)
				add_word(pick_octet(25), i == plen - 1);
			count += 3 + plen;
		end
	endtask

	// Hold until every word has gone in and every wire word has come out
	task automatic wait_drained();
		while (frame_words.size() != 0 || in_valid || wire_queue.size() != 0)
			@(negedge clk);
	endtask

	// Drive input words; present the next one once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				encode_word(data_byte, last_byte);
			if (!in_valid || !in_stall) begin
				if (frame_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid  <= 1'b1;
					data_byte <= frame_words[0].data;
					last_byte <= frame_words[0].last;
					void'(frame_words.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check wire words against the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (wire_queue.size() == 0) begin
					$display("%0t: unexpected wire word: expected none, actual %h end %b",
						$time, out_byte, frame_end);
					err_count++;
				end else begin
					want = wire_queue.pop_front();
					if (out_byte !== want.octet) begin
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, want.octet, out_byte);
						err_count++;
					end
					if (frame_end !== want.is_end) begin
						$display("%0t: frame_end mismatch: expected %b, actual %b",
							$time, want.is_end, frame_end);
						err_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		wait (arst_n);
		@(negedge clk);

		// first pass: sender idles lightly, receiver heavily
		send_idle_pct = 14;
		recv_idle_pct = 46;

		// special checksum 0x7D, length 0x0001
		add_word(START_DLM, 1'b0); add_word(8'h00, 1'b0);
		add_word(8'h01, 1'b0); add_word(8'h82, 1'b1);
		// odd delimiter, special length bytes, early flags ignored, checksum 0x13
		add_word(ESC_MARK, 1'b1); add_word(START_DLM, 1'b1);
		add_word(XON_CHAR, 1'b1); add_word(XOFF_CHAR, 1'b0);
		add_word(8'h00, 1'b0); add_word(8'hD9, 1'b1);
		// zero delimiter; escaped last byte followed by escaped checksum
		add_word(8'h00, 1'b0); add_word(XOFF_CHAR, 1'b0);
		add_word(ESC_MARK, 1'b0); add_word(8'h03, 1'b0);
		add_word(START_DLM, 1'b1);
		// all-ones bytes, checksum 0x7E
		add_word(8'hFF, 1'b0); add_word(8'hFF, 1'b0);
		add_word(8'hFF, 1'b0); add_word(8'h81, 1'b1);
		// checksum 0x11
		add_word(START_DLM, 1'b0); add_word(8'h00, 1'b0);
		add_word(8'h02, 1'b0); add_word(8'hEE, 1'b1);

		queue_frames(100);
		wait_drained();

		// second pass: roles swapped
		send_idle_pct = 46;
		recv_idle_pct = 14;
		queue_frames(110);
		wait_drained();

		// last pass: full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_frames(110);
		wait_drained();

		repeat (8) @(negedge clk);
		if (err_count == 0 && wire_queue.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
